// ===== hw/rtl/obp_pkg.sv =====
package obp_pkg;

	localparam int COORD_W = 32;
	localparam int DEPTH_W = 4;
	localparam int PATH_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_LEVELS_DEF = 8;
	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROOT_MIN_X,
		REG_ROOT_MIN_Y,
		REG_ROOT_MIN_Z,
		REG_ROOT_MAX_X,
		REG_ROOT_MAX_Y,
		REG_ROOT_MAX_Z,
		REG_DEPTH_LIMIT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REASON_STRADDLE,
		REASON_NO_FIT,
		REASON_DEPTH,
		REASON_OUTSIDE
	} reason_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_min_z;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] box_max_z;
	} box_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] placement_depth;
		logic [PATH_W-1:0]  octant_path;
		logic [1:0]         stop_reason;
	} place_t;

	typedef struct packed {
		logic    load;
		logic    descend;
		logic    emit;
		reason_t reason;
	} obp_cmd_t;

	typedef struct packed {
		logic outside;
		logic straddle;
		logic at_limit;
		logic no_fit;
	} obp_status_t;

endpackage

// ===== hw/rtl/obp_ctrl.sv =====
module obp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 box_valid,
	output logic                 box_ready,
	output logic                 place_valid,
	input  logic                 place_ready,
	input  obp_pkg::obp_status_t status,
	output obp_pkg::obp_cmd_t    cmd
);
	import obp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_STEP
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   out_free;

	always_comb begin
		out_free = !valid_q || place_ready;
		box_ready = (state_q == ST_IDLE);
		place_valid = valid_q;
		cmd = '0;
		cmd.reason = REASON_STRADDLE;
		case (state_q)
			ST_IDLE: begin
				cmd.load = box_valid;
			end
			ST_ROOT: begin
				if (status.outside) begin
					cmd.emit = out_free;
					cmd.reason = REASON_OUTSIDE;
				end
			end
			ST_STEP: begin
				if (status.straddle) begin
					cmd.emit = out_free;
					cmd.reason = REASON_STRADDLE;
				end else if (status.at_limit) begin
					cmd.emit = out_free;
					cmd.reason = REASON_DEPTH;
				end else if (status.no_fit) begin
					cmd.emit = out_free;
					cmd.reason = REASON_NO_FIT;
				end else begin
					cmd.descend = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (place_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (box_valid) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (!status.outside) begin
						state_q <= ST_STEP;
					end else if (cmd.emit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_STEP: begin
					if (cmd.emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/obp_dpath.sv =====
module obp_dpath #(
	parameter int MAX_LEVELS = obp_pkg::MAX_LEVELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [obp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [obp_pkg::COORD_W-1:0]       cfg_data,
	input  obp_pkg::box_t                     box,
	input  obp_pkg::obp_cmd_t                 cmd,
	output obp_pkg::obp_status_t              status,
	output obp_pkg::place_t                   place
);
	import obp_pkg::*;

	localparam int EW = COORD_W + 2;
	localparam int DW = $clog2(MAX_LEVELS + 1);
	localparam int LW = (DW > DEPTH_W) ? DW : DEPTH_W;
	localparam int PW = 3 * MAX_LEVELS;
	localparam int PXW = (PW > PATH_W) ? PW : PATH_W;

	// configuration
	logic signed [COORD_W-1:0] root_lo_q [3];
	logic signed [COORD_W-1:0] root_hi_q [3];
	logic [DEPTH_W-1:0]        limit_q;

	// working cell and box terms
	logic signed [COORD_W-1:0] bmin_q [3];
	logic signed [COORD_W-1:0] bmax_q [3];
	logic signed [COORD_W:0]   tmin2_q [3];
	logic signed [COORD_W:0]   tmax2_q [3];
	logic signed [COORD_W:0]   bsum_q [3];
	logic signed [COORD_W+1:0] bext2_q [3];
	logic signed [COORD_W-1:0] lo_q [3];
	logic signed [COORD_W-1:0] hi_q [3];
	logic [DW-1:0]             depth_q;
	logic [PW-1:0]             path_q;
	place_t                    place_q;

	logic signed [COORD_W-1:0] in_min [3];
	logic signed [COORD_W-1:0] in_max [3];
	logic signed [EW-1:0]      csum [3];
	logic signed [EW-1:0]      cext [3];
	logic signed [EW-1:0]      half [3];
	logic signed [COORD_W:0]   bdiff [3];
	logic [2:0]                oct;
	logic [LW-1:0]             limit_ext;
	logic [LW-1:0]             limit_eff;
	logic [LW-1:0]             depth_ext;
	logic [PXW-1:0]            path_ext;

	always_comb begin
		in_min[0] = box.box_min_x;
		in_min[1] = box.box_min_y;
		in_min[2] = box.box_min_z;
		in_max[0] = box.box_max_x;
		in_max[1] = box.box_max_y;
		in_max[2] = box.box_max_z;
		status = '0;
		oct = '0;
		for (int a = 0; a < 3; a++) begin
			bdiff[a] = (COORD_W + 1)'(in_max[a]) - (COORD_W + 1)'(in_min[a]);
			csum[a] = EW'(lo_q[a]) + EW'(hi_q[a]);
			cext[a] = EW'(hi_q[a]) - EW'(lo_q[a]);
			half[a] = csum[a] >>> 1;
			if (bmin_q[a] < root_lo_q[a] || bmax_q[a] > root_hi_q[a]) begin
				status.outside = 1'b1;
			end
			if (EW'(tmax2_q[a]) > csum[a] && EW'(tmin2_q[a]) < csum[a]) begin
				status.straddle = 1'b1;
			end
			if (EW'(bext2_q[a]) > cext[a]) begin
				status.no_fit = 1'b1;
			end
			oct[a] = (EW'(bsum_q[a]) > csum[a]);
		end
		limit_ext = LW'(limit_q);
		limit_eff = (limit_ext > LW'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : limit_ext;
		depth_ext = LW'(depth_q);
		status.at_limit = (depth_ext >= limit_eff);
		path_ext = PXW'(path_q);
		place = place_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				root_lo_q[a] <= '0;
				root_hi_q[a] <= '0;
			end
			limit_q <= DEPTH_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROOT_MIN_X: root_lo_q[0] <= cfg_data;
				REG_ROOT_MIN_Y: root_lo_q[1] <= cfg_data;
				REG_ROOT_MIN_Z: root_lo_q[2] <= cfg_data;
				REG_ROOT_MAX_X: root_hi_q[0] <= cfg_data;
				REG_ROOT_MAX_Y: root_hi_q[1] <= cfg_data;
				REG_ROOT_MAX_Z: root_hi_q[2] <= cfg_data;
				REG_DEPTH_LIMIT: limit_q <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				bmin_q[a] <= in_min[a];
				bmax_q[a] <= in_max[a];
				tmin2_q[a] <= {in_min[a], 1'b0};
				tmax2_q[a] <= {in_max[a], 1'b0};
				bsum_q[a] <= (COORD_W + 1)'(in_min[a]) + (COORD_W + 1)'(in_max[a]);
				bext2_q[a] <= {bdiff[a], 1'b0};
				lo_q[a] <= root_lo_q[a];
				hi_q[a] <= root_hi_q[a];
			end
			depth_q <= '0;
			path_q <= '0;
		end else if (cmd.descend) begin
			for (int a = 0; a < 3; a++) begin
				if (oct[a]) begin
					lo_q[a] <= half[a][COORD_W-1:0];
				end else begin
					hi_q[a] <= half[a][COORD_W-1:0];
				end
			end
			depth_q <= depth_q + 1'b1;
			path_q <= path_q | (PW'(oct) << (3 * depth_q));
		end
		if (cmd.emit) begin
			place_q.placement_depth <= depth_ext[DEPTH_W-1:0];
			place_q.octant_path <= path_ext[PATH_W-1:0];
			place_q.stop_reason <= cmd.reason;
		end
	end

endmodule

// ===== hw/rtl/octree_box_placement.sv =====
// flow: a box is loaded and checked against the root; one outside the root is placed
//   at the root, else the cell descends until the box straddles, reaches the depth
//   limit (at most MAX_LEVELS) or no longer fits; emission waits for output room
// one shared level unit walks the cell down one level per cycle, one box at a time
// reset: control and configuration cleared at once (root bounds 0, depth limit 8),
//   ready as soon as reset is released
module octree_box_placement #(
	parameter int MAX_LEVELS = obp_pkg::MAX_LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [obp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [obp_pkg::COORD_W-1:0]   cfg_data,
	input  logic                          box_valid,
	output logic                          box_ready,
	input  obp_pkg::box_t                 box,
	output logic                          place_valid,
	input  logic                          place_ready,
	output obp_pkg::place_t               place
);
	import obp_pkg::*;

	obp_cmd_t    cmd;
	obp_status_t status;

	obp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.box_valid   (box_valid),
		.box_ready   (box_ready),
		.place_valid (place_valid),
		.place_ready (place_ready),
		.status      (status),
		.cmd         (cmd)
	);

	obp_dpath #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.box      (box),
		.cmd      (cmd),
		.status   (status),
		.place    (place)
	);

`ifndef ASSERT_OFF
	a_one_box_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_ready |=> !box_ready)
		else $error("box accepted while busy");

	a_outside_at_root: assert property (@(posedge clk) disable iff (!arst_n)
		place_valid && place.stop_reason == REASON_OUTSIDE
		|-> place.placement_depth == '0 && place.octant_path == '0)
		else $error("outside box not placed at root");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		place_valid |-> (MAX_LEVELS > 15) || (int'(place.placement_depth) <= MAX_LEVELS))
		else $error("placement deeper than level count");

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !place_valid || place_ready)
		else $error("result overwritten before taken");
`endif

endmodule
